FILE: hw/rtl/sbsr_pkg.sv
// ----------------------------------------------------------------------------
// Superbee slope reconstruction package
// Types, widths and limiter codes shared by the reconstruction pipeline.
// ----------------------------------------------------------------------------
package sbsr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int RATIO_CAP  = 99999;

    localparam int DIFF_W = DATA_WIDTH + 1;
    localparam int DIV_W  = DATA_WIDTH + 2;
    localparam int QW     = FRAC_BITS + 1;
    localparam int STEPS  = FRAC_BITS + 1;
    localparam int PROD_W = QW + DIFF_W;

    localparam logic [QW-1:0] PHI_ONE = QW'(1) << FRAC_BITS;
    localparam logic [QW-1:0] PHI_CAP = QW'((2 << FRAC_BITS) / (RATIO_CAP + 1));

    localparam logic [1:0] MODE_ZERO = 2'd0;
    localparam logic [1:0] MODE_ONE  = 2'd1;
    localparam logic [1:0] MODE_CAP  = 2'd2;
    localparam logic [1:0] MODE_DIV  = 2'd3;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] left_value;
        logic signed [DATA_WIDTH-1:0] centre_value;
        logic signed [DATA_WIDTH-1:0] right_value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] backward_face;
        logic signed [DATA_WIDTH-1:0] forward_face;
    } t_out;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] centre;
        logic signed [DIFF_W-1:0]     span;
        logic [1:0]                   mode;
        logic [DIV_W-1:0]             rem;
        logic [DIV_W-1:0]             divisor;
        logic [QW-1:0]                quot;
    } t_div;

endpackage

FILE: hw/rtl/sbsr_front.sv
// ----------------------------------------------------------------------------
// Superbee front stage
// Forms the one-sided differences, classifies the slope ratio and sets up
// the divider operands.
// ----------------------------------------------------------------------------
module sbsr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  sbsr_pkg::t_in i_data,
    output logic          o_valid,
    output sbsr_pkg::t_div o_stage
);
    import sbsr_pkg::*;

    logic                     r_valid;
    t_div                     r_stage;
    t_div                     n_stage;
    logic signed [DIFF_W-1:0] dl;
    logic signed [DIFF_W-1:0] dr;
    logic [DIFF_W-1:0]        a;
    logic [DIFF_W-1:0]        b;

    always_comb begin
        dl = {i_data.centre_value[DATA_WIDTH-1], i_data.centre_value}
           - {i_data.left_value[DATA_WIDTH-1], i_data.left_value};
        dr = {i_data.right_value[DATA_WIDTH-1], i_data.right_value}
           - {i_data.centre_value[DATA_WIDTH-1], i_data.centre_value};
        a = dl[DIFF_W-1] ? -dl : dl;
        b = dr[DIFF_W-1] ? -dr : dr;
        n_stage.centre  = i_data.centre_value;
        n_stage.span    = {i_data.right_value[DATA_WIDTH-1], i_data.right_value}
                        - {i_data.left_value[DATA_WIDTH-1], i_data.left_value};
        n_stage.quot    = '0;
        n_stage.rem     = '0;
        n_stage.divisor = DIV_W'(1);
        if (dr == '0) begin
            n_stage.mode = (dl != '0) ? MODE_CAP : MODE_ONE;
        end else if (dl == '0 || (dl[DIFF_W-1] != dr[DIFF_W-1])) begin
            n_stage.mode = MODE_ZERO;
        end else if ({a, 1'b0} <= {1'b0, b}) begin
            n_stage.mode    = MODE_DIV;
            n_stage.rem     = DIV_W'(a);
            n_stage.divisor = DIV_W'(b);
        end else if (a <= b) begin
            n_stage.mode = MODE_ONE;
        end else begin
            n_stage.mode    = MODE_DIV;
            n_stage.rem     = DIV_W'(b);
            n_stage.divisor = DIV_W'(a) + DIV_W'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: hw/rtl/sbsr_div_cell.sv
// ----------------------------------------------------------------------------
// Superbee divider cell
// One restoring division step: produces one quotient bit and hands the
// partial remainder to the next cell.
// ----------------------------------------------------------------------------
module sbsr_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  sbsr_pkg::t_div i_stage,
    output logic           o_valid,
    output sbsr_pkg::t_div o_stage
);
    import sbsr_pkg::*;

    logic             r_valid;
    t_div             r_stage;
    t_div             n_stage;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   diff;

    always_comb begin
        rem_sh  = {i_stage.rem, 1'b0};
        diff    = rem_sh - {1'b0, i_stage.divisor};
        n_stage = i_stage;
        if (!diff[DIV_W]) begin
            n_stage.rem  = diff[DIV_W-1:0];
            n_stage.quot = {i_stage.quot[QW-2:0], 1'b1};
        end else begin
            n_stage.rem  = rem_sh[DIV_W-1:0];
            n_stage.quot = {i_stage.quot[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

FILE: hw/rtl/sbsr_back.sv
// ----------------------------------------------------------------------------
// Superbee back stage
// Selects the limiter, scales the span by it and forms the saturated faces.
// ----------------------------------------------------------------------------
module sbsr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  sbsr_pkg::t_div i_stage,
    output logic           o_valid,
    output sbsr_pkg::t_out o_data
);
    import sbsr_pkg::*;

    localparam logic signed [DATA_WIDTH+1:0] MAX_V =
        (DATA_WIDTH+2)'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam logic signed [DATA_WIDTH+1:0] MIN_V = -MAX_V - 1;

    logic                          r_valid_m;
    logic                          r_valid;
    logic [PROD_W-1:0]             r_prod;
    logic                          r_neg;
    logic signed [DATA_WIDTH-1:0]  r_centre;
    t_out                          r_data;
    logic [QW-1:0]                 phi;
    logic [DIFF_W-1:0]             mag;
    logic [DATA_WIDTH-1:0]         corr;
    logic signed [DATA_WIDTH+1:0]  delta;
    logic signed [DATA_WIDTH+1:0]  c_ext;
    logic signed [DATA_WIDTH+1:0]  lo_sum;
    logic signed [DATA_WIDTH+1:0]  hi_sum;
    t_out                          n_data;

    function automatic logic signed [DATA_WIDTH-1:0] sat(
        input logic signed [DATA_WIDTH+1:0] v
    );
        if (v > MAX_V) begin
            return MAX_V[DATA_WIDTH-1:0];
        end else if (v < MIN_V) begin
            return MIN_V[DATA_WIDTH-1:0];
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    always_comb begin
        case (i_stage.mode)
            MODE_DIV: phi = i_stage.quot;
            MODE_ONE: phi = PHI_ONE;
            MODE_CAP: phi = PHI_CAP;
            default:  phi = '0;
        endcase
        mag = i_stage.span[DIFF_W-1] ? -i_stage.span : i_stage.span;
    end

    always_comb begin
        corr   = r_prod[PROD_W-1 -: DATA_WIDTH] >> (PROD_W - DATA_WIDTH - FRAC_BITS - 2);
        delta  = r_neg ? -$signed({2'b00, corr}) : $signed({2'b00, corr});
        c_ext  = {{2{r_centre[DATA_WIDTH-1]}}, r_centre};
        lo_sum = c_ext - delta;
        hi_sum = c_ext + delta;
        n_data.backward_face = sat(lo_sum);
        n_data.forward_face  = sat(hi_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_m <= 1'b0;
            r_valid   <= 1'b0;
        end else if (i_en) begin
            r_valid_m <= i_valid;
            r_valid   <= r_valid_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= PROD_W'(phi) * PROD_W'(mag);
            r_neg    <= i_stage.span[DIFF_W-1];
            r_centre <= i_stage.centre;
            r_data   <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hw/rtl/superbee_slope_reconstruction.sv
// Registered in order: front stage, divider cells, back product, back faces.
// Throughput: one transfer per cycle unless the output stalls; FRAC_BITS + 1 divider
// cells produce one quotient bit per cell, so every stage holds a different stencil.
// The whole pipeline advances together and holds only while the output stalls.
// Reset is synchronous and active low and clears all valid flags.
// ----------------------------------------------------------------------------
// Superbee slope reconstruction
// MUSCL face reconstruction with the superbee limiter as a pipelined chain.
// ----------------------------------------------------------------------------
module superbee_slope_reconstruction (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sbsr_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output sbsr_pkg::t_out o_out_data
);
    import sbsr_pkg::*;

    logic en;
    logic v [0:STEPS];
    t_div st [0:STEPS];

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    sbsr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (v[0]),
        .o_stage (st[0])
    );

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        sbsr_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[k]),
            .i_stage (st[k]),
            .o_valid (v[k+1]),
            .o_stage (st[k+1])
        );
    end

    sbsr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v[STEPS]),
        .i_stage (st[STEPS]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without an output stall");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
    a_cell_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(v[STEPS]))
        else $error("divider chain advanced during output stall");
`endif

endmodule
